// File: rtl/cpgd_pkg.sv
package cpgd_pkg;

  // Grid and number format
  localparam int GRID_SIZE  = 32;
  localparam int GRID_BITS  = $clog2(GRID_SIZE);
  localparam int ADDR_W     = 3 * GRID_BITS;
  localparam int NCELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_WIDTH  = 48;

  // Field widths
  localparam int POS_W      = 21;
  localparam int MASS_W     = 24;
  localparam int CELL_W     = 15;
  localparam int OUT_W      = 48;
  localparam int SCALE_W    = 32;

  // Internal widths
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int VAL_W      = MASS_W;
  localparam int SUM_LO_W   = 32;
  localparam int SUM_HI_W   = SUM_WIDTH - SUM_LO_W;
  localparam int PROD_W     = SUM_WIDTH + SCALE_W;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Result queue
  localparam int OUT_DEPTH  = 2;
  localparam int PTR_W      = $clog2(OUT_DEPTH);
  localparam int PEND_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [WGT_W-1:0]     WGT_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [WGT_W-1:0]     WGT_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MAX  = '1;
  localparam logic [OUT_W-1:0]     OUT_MAX  = '1;

  localparam logic CMD_DEPOSIT = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic MODE_NGP    = 1'b0;
  localparam logic MODE_CIC    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ASSIGN_MODE   = 2'd0,
    REG_USE_MASS      = 2'd1,
    REG_DENSITY_SCALE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORNERS
  } seq_state_t;

  // One grid operation on its way through the weight pipeline
  typedef struct packed {
    logic              valid;
    logic              is_read;
    logic              is_ngp;
    logic              use_mass;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] echo;
    logic [WGT_W-1:0]  wa;
    logic [WGT_W-1:0]  wb;
    logic [WGT_W-1:0]  wc;
    logic [MASS_W-1:0] mass;
  } op_t;

  // Memory read request
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  // Operation at the read-modify-write stage
  typedef struct packed {
    logic              valid;
    logic              is_read;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] echo;
    logic [VAL_W-1:0]  value;
  } acc_op_t;

  typedef struct packed {
    logic [CELL_W-1:0] echo;
    logic [OUT_W-1:0]  density;
  } res_t;

endpackage

// File: rtl/cpgd_cell_ram.sv
module cpgd_cell_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cpgd_seq.sv
module cpgd_seq import cpgd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  input  logic [POS_W-1:0]  pos_z,
  input  logic [MASS_W-1:0] mass,
  input  logic [CELL_W-1:0] read_cell,
  input  logic              assign_mode,
  input  logic              use_mass,
  input  logic              out_done,
  output op_t               issue,
  output logic              clr_we,
  output logic [ADDR_W-1:0] clr_addr
);

  typedef struct packed {
    logic [GRID_BITS-1:0] lo;
    logic [WGT_W-1:0]     w_lo;
    logic [WGT_W-1:0]     w_hi;
  } axis_t;

  // Lower of the two cells that get a share on one axis, and the two tent weights.
  function automatic axis_t split_axis(input logic [POS_W-1:0] pos);
    axis_t                a;
    logic [WGT_W-1:0]     f;
    logic [GRID_BITS-1:0] k;
    f = {1'b0, pos[FRAC_BITS-1:0]};
    k = pos[FRAC_BITS +: GRID_BITS];
    if (f < WGT_HALF) begin
      a.lo   = k - 1'b1;
      a.w_lo = WGT_HALF - f;
      a.w_hi = WGT_HALF + f;
    end else begin
      a.lo   = k;
      a.w_lo = WGT_ONE - (f - WGT_HALF);
      a.w_hi = f - WGT_HALF;
    end
    return a;
  endfunction

  function automatic op_t corner_op(input axis_t ax, input axis_t ay, input axis_t az,
                                    input logic [2:0] c, input logic [MASS_W-1:0] m,
                                    input logic um);
    op_t                  op;
    logic [GRID_BITS-1:0] cx;
    logic [GRID_BITS-1:0] cy;
    logic [GRID_BITS-1:0] cz;
    cx = c[2] ? ax.lo + 1'b1 : ax.lo;
    cy = c[1] ? ay.lo + 1'b1 : ay.lo;
    cz = c[0] ? az.lo + 1'b1 : az.lo;
    op          = '0;
    op.valid    = 1'b1;
    op.use_mass = um;
    op.in_range = 1'b1;
    op.addr     = {cx, cy, cz};
    op.wa       = c[2] ? ax.w_hi : ax.w_lo;
    op.wb       = c[1] ? ay.w_hi : ay.w_lo;
    op.wc       = c[0] ? az.w_hi : az.w_lo;
    op.mass     = m;
    return op;
  endfunction

  seq_state_t        state;
  seq_state_t        state_next;
  op_t               issue_next;
  logic [2:0]        corner;
  axis_t             hx;
  axis_t             hy;
  axis_t             hz;
  logic [MASS_W-1:0] hmass;
  logic [PEND_W-1:0] pend;
  axis_t             ax_i;
  axis_t             ay_i;
  axis_t             az_i;
  logic              acc;
  logic              acc_read;

  assign ax_i     = split_axis(pos_x);
  assign ay_i     = split_axis(pos_y);
  assign az_i     = split_axis(pos_z);
  assign in_ready = (state == ST_IDLE) && (pend < PEND_W'(OUT_DEPTH));
  assign acc      = in_valid && in_ready;
  assign acc_read = acc && (cmd == CMD_READ);
  assign clr_we   = (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue_next = '0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          if (cmd == CMD_READ) begin
            issue_next.valid    = 1'b1;
            issue_next.is_read  = 1'b1;
            issue_next.addr     = read_cell[ADDR_W-1:0];
            issue_next.echo     = read_cell;
            issue_next.in_range = {1'b0, read_cell} < (CELL_W + 1)'(NCELLS);
          end else if (assign_mode == MODE_NGP) begin
            issue_next.valid    = 1'b1;
            issue_next.is_ngp   = 1'b1;
            issue_next.use_mass = use_mass;
            issue_next.in_range = 1'b1;
            issue_next.addr     = {pos_x[FRAC_BITS +: GRID_BITS],
                                   pos_y[FRAC_BITS +: GRID_BITS],
                                   pos_z[FRAC_BITS +: GRID_BITS]};
            issue_next.mass     = mass;
          end else begin
            issue_next = corner_op(ax_i, ay_i, az_i, 3'd0, mass, use_mass);
            state_next = ST_CORNERS;
          end
        end
      end
      ST_CORNERS: begin
        issue_next = corner_op(hx, hy, hz, corner, hmass, use_mass);
        if (corner == '1) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue.valid <= 1'b0;
      clr_addr    <= '0;
      pend        <= '0;
      corner      <= '0;
    end else begin
      issue <= issue_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (acc) begin
        corner <= 3'd1;
      end else if (state == ST_CORNERS) begin
        corner <= corner + 1'b1;
      end
      if (acc_read && !out_done) begin
        pend <= pend + 1'b1;
      end else if (!acc_read && out_done) begin
        pend <= pend - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hx    <= ax_i;
      hy    <= ay_i;
      hz    <= az_i;
      hmass <= mass;
    end
  end

endmodule

// File: rtl/cpgd_wgt_pipe.sv
module cpgd_wgt_pipe import cpgd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  op_t     s1,
  output ram_rd_t rd,
  output acc_op_t s4
);

  op_t                       s2;
  op_t                       s3;
  op_t                       s2_next;
  op_t                       s3_next;
  logic [2*WGT_W-1:0]        prod_ab;
  logic [2*WGT_W-1:0]        prod_c;
  logic [WGT_W+MASS_W-1:0]   prod_m;
  logic [VAL_W-1:0]          value;

  // Weight product is formed in two truncating steps, then optionally times mass.
  assign prod_ab = s1.wa * s1.wb;
  assign prod_c  = s2.wa * s2.wc;
  assign prod_m  = s3.wa * s3.mass;

  always_comb begin
    s2_next    = s1;
    s2_next.wa = prod_ab[FRAC_BITS +: WGT_W];
    s3_next    = s2;
    s3_next.wa = prod_c[FRAC_BITS +: WGT_W];
  end

  always_comb begin
    if (s3.is_ngp) begin
      value = s3.use_mass ? s3.mass : VAL_W'(WGT_ONE);
    end else begin
      value = s3.use_mass ? prod_m[FRAC_BITS +: VAL_W] : VAL_W'(s3.wa);
    end
  end

  assign rd.valid = s3.valid;
  assign rd.addr  = s3.addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
    end else begin
      s2          <= s2_next;
      s3          <= s3_next;
      s4.valid    <= s3.valid;
      s4.is_read  <= s3.is_read;
      s4.in_range <= s3.in_range;
      s4.addr     <= s3.addr;
      s4.echo     <= s3.echo;
      s4.value    <= value;
    end
  end

endmodule

// File: rtl/cpgd_accum.sv
module cpgd_accum import cpgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  acc_op_t              s4,
  input  ram_rd_t              rd,
  input  logic [SUM_WIDTH-1:0] rdata,
  input  logic [SCALE_W-1:0]   scale,
  output logic                 we,
  output logic [ADDR_W-1:0]    waddr,
  output logic [SUM_WIDTH-1:0] wdata,
  output logic                 res_valid,
  output res_t                 res
);

  logic                          fwd_hit;
  logic [SUM_WIDTH-1:0]          fwd_data;
  logic [SUM_WIDTH-1:0]          cur;
  logic [SUM_WIDTH:0]            sum_ext;
  logic [SUM_WIDTH-1:0]          new_sum;
  logic                          p_valid;
  logic                          p_in_range;
  logic [CELL_W-1:0]             p_echo;
  logic [SUM_LO_W+SCALE_W-1:0]   p_lo;
  logic [SUM_HI_W+SCALE_W-1:0]   p_hi;
  logic [PROD_W-1:0]             total;

  // The memory read for the next operation happens at the same edge as this
  // write, so a read of the same cell sees the old value; the new one is forwarded.
  assign cur     = fwd_hit ? fwd_data : rdata;
  assign sum_ext = {1'b0, cur} + (SUM_WIDTH + 1)'(s4.value);
  assign new_sum = sum_ext[SUM_WIDTH] ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];

  assign we    = s4.valid && !s4.is_read;
  assign waddr = s4.addr;
  assign wdata = new_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      fwd_hit <= we && rd.valid && (rd.addr == s4.addr);
      p_valid <= s4.valid && s4.is_read;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data   <= new_sum;
    p_in_range <= s4.in_range;
    p_echo     <= s4.echo;
    p_lo       <= cur[SUM_LO_W-1:0] * scale;
    p_hi       <= cur[SUM_WIDTH-1:SUM_LO_W] * scale;
  end

  assign total = PROD_W'(p_lo) + {p_hi, {SUM_LO_W{1'b0}}};

  always_comb begin
    res.echo = p_echo;
    if (!p_in_range) begin
      res.density = '0;
    end else if (total[PROD_W-1:OUT_W+FRAC_BITS] != '0) begin
      res.density = OUT_MAX;
    end else begin
      res.density = total[FRAC_BITS +: OUT_W];
    end
  end

  assign res_valid = p_valid;

endmodule

// File: rtl/cpgd_out_fifo.sv
module cpgd_out_fifo import cpgd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic valid,
  input  logic ready,
  output res_t dout
);

  res_t              mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PEND_W-1:0] count;
  logic              pop;

  assign valid = (count != '0);
  assign pop   = valid && ready;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/cic_particle_grid_deposit.sv
// Particle deposit onto a periodic 32x32x32 density grid with cell readout.
//
// Input stream (s_axis): tuser carries the command, 0 for a particle deposit and
// 1 for a cell read. A deposit adds the particle to the grid sums and returns
// nothing; a read returns one transfer on the output stream (m_axis) with the
// cell sum scaled by density_scale and the echoed cell index. Configuration
// (cfg_we, cfg_index, cfg_data) is to be written by the user only while the
// block is idle; the block itself does not enforce this.
// A cloud-in-cell deposit makes one read-modify-write of the grid memory per
// neighbouring cell through its single write port, and no new item is taken
// until all eight are issued. A nearest-grid-point deposit or a read makes a
// single access, and the next item may follow straight on. A read result
// reaches m_axis behind the weight multipliers, the memory read, the scaling
// multipliers and the result queue.
// After reset the grid memory is cleared one cell per cycle, with s_axis_tready
// held low. Results sit in a two-entry queue; while the receiver stalls, the
// block takes no further item, deposit or read, once two results are owed,
// so nothing is ever dropped.
module cic_particle_grid_deposit import cpgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[20:0], pos_y[41:21], pos_z[62:42], particle_mass[86:63],
  // read_cell[101:87], zero fill above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // cell_density[47:0], cell_echo[62:48], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 assign_mode;
  logic                 use_mass;
  logic [SCALE_W-1:0]   density_scale;

  op_t                  issue;
  ram_rd_t              rd;
  acc_op_t              s4;
  logic                 clr_we;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 acc_we;
  logic [ADDR_W-1:0]    acc_waddr;
  logic [SUM_WIDTH-1:0] acc_wdata;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [SUM_WIDTH-1:0] ram_wdata;
  logic [SUM_WIDTH-1:0] ram_rdata;
  logic                 res_valid;
  res_t                 res;
  res_t                 dout;
  logic                 out_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      assign_mode   <= MODE_CIC;
      use_mass      <= 1'b0;
      density_scale <= SCALE_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ASSIGN_MODE:   assign_mode   <= cfg_data[0];
        REG_USE_MASS:      use_mass      <= cfg_data[0];
        REG_DENSITY_SCALE: density_scale <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_done = m_axis_tvalid && m_axis_tready;

  // Front end: accepts items, runs the clearing pass and steps through the
  // eight neighbour cells of a cloud-in-cell deposit.
  cpgd_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .cmd         (s_axis_tuser),
    .pos_x       (s_axis_tdata[20:0]),
    .pos_y       (s_axis_tdata[41:21]),
    .pos_z       (s_axis_tdata[62:42]),
    .mass        (s_axis_tdata[86:63]),
    .read_cell   (s_axis_tdata[101:87]),
    .assign_mode (assign_mode),
    .use_mass    (use_mass),
    .out_done    (out_done),
    .issue       (issue),
    .clr_we      (clr_we),
    .clr_addr    (clr_addr)
  );

  // Tent-weight products, one operation per cycle.
  cpgd_wgt_pipe u_wgt_pipe (
    .clk (clk),
    .rst (rst),
    .s1  (issue),
    .rd  (rd),
    .s4  (s4)
  );

  // The clearing pass owns the write port only while no operation is in flight.
  assign ram_we    = clr_we || acc_we;
  assign ram_waddr = clr_we ? clr_addr : acc_waddr;
  assign ram_wdata = clr_we ? '0 : acc_wdata;

  cpgd_cell_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_WIDTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd.addr),
    .rdata (ram_rdata)
  );

  // Saturating accumulate with write-to-read forwarding, and readout scaling.
  cpgd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .s4        (s4),
    .rd        (rd),
    .rdata     (ram_rdata),
    .scale     (density_scale),
    .we        (acc_we),
    .waddr     (acc_waddr),
    .wdata     (acc_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  cpgd_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .valid (m_axis_tvalid),
    .ready (m_axis_tready),
    .dout  (dout)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OUT_W - CELL_W){1'b0}}, dout.echo, dout.density};

endmodule

// File: dv/cpgd_tb_pkg.sv
package cpgd_tb_pkg;
  import cpgd_pkg::*;

  // Tent weights of one axis: cell k-1, cell k, cell k+1.
  typedef logic [2:0][WGT_W-1:0] tent_t;

  typedef struct packed {
    logic [CELL_W-1:0] echo;
    logic [OUT_W-1:0]  density;
  } cell_read_t;

  // Mirror of the density grid: applies every accepted deposit to its own copy of
  // the cell sums and queues the scaled value that each accepted read must return.
  class grid_scoreboard;
    logic [SUM_WIDTH-1:0] sums [NCELLS];
    logic                 mode;
    logic                 use_mass;
    logic [SCALE_W-1:0]   scale;
    cell_read_t           owed [$];
    int                   mismatches;
    int                   reads_checked;
    int                   saturated_reads;
    int                   ngp_deposits;
    int                   cic_deposits;

    function new();
      foreach (sums[i]) sums[i] = '0;
      mode            = MODE_CIC;
      use_mass        = 1'b0;
      scale           = SCALE_W'(65536);
      mismatches      = 0;
      reads_checked   = 0;
      saturated_reads = 0;
      ngp_deposits    = 0;
      cic_deposits    = 0;
    endfunction

    function void write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ASSIGN_MODE:   mode = value[0];
        REG_USE_MASS:      use_mass = value[0];
        REG_DENSITY_SCALE: scale = value;
        default: ;
      endcase
    endfunction

    function tent_t tent(input logic [FRAC_BITS-1:0] f);
      logic [WGT_W-1:0] fe;
      tent_t            w;
      fe = {1'b0, f};
      w  = '0;
      if (fe < WGT_HALF) begin
        w[0] = WGT_HALF - fe;
        w[1] = WGT_ONE - (WGT_HALF - fe);
      end else begin
        w[1] = WGT_ONE - (fe - WGT_HALF);
        w[2] = fe - WGT_HALF;
      end
      return w;
    endfunction

    function void add_to_cell(input logic [CELL_W-1:0] cell_idx, input bit [63:0] v);
      bit [63:0] s;
      s = 64'(sums[cell_idx]) + v;
      if (s > 64'(SUM_MAX)) s = 64'(SUM_MAX);
      sums[cell_idx] = s[SUM_WIDTH-1:0];
    endfunction

    function void report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    // Called once per accepted input transfer, in acceptance order.
    function void note_item(input logic cmd, input logic [POS_W-1:0] px, py, pz,
                            input logic [MASS_W-1:0] mass,
                            input logic [CELL_W-1:0] cell_idx);
      logic [2:0][POS_W-1:0]     pos;
      logic [2:0][GRID_BITS-1:0] k;
      tent_t                     w [3];
      bit [63:0]                 t;
      bit [63:0]                 wp;
      bit [63:0]                 v;
      logic [GRID_BITS-1:0]      cx, cy, cz;
      bit [PROD_W-1:0]           prod;
      cell_read_t                r;
      if (cmd == CMD_READ) begin
        prod      = PROD_W'(sums[cell_idx]) * PROD_W'(scale);
        prod      = prod >> FRAC_BITS;
        r.echo    = cell_idx;
        r.density = (prod > PROD_W'(OUT_MAX)) ? OUT_MAX : prod[OUT_W-1:0];
        owed.push_back(r);
        return;
      end
      pos = {pz, py, px};
      for (int a = 0; a < 3; a++) begin
        k[a] = pos[a][FRAC_BITS +: GRID_BITS];
        w[a] = tent(pos[a][FRAC_BITS-1:0]);
      end
      if (mode == MODE_NGP) begin
        ngp_deposits++;
        add_to_cell({k[0], k[1], k[2]}, use_mass ? 64'(mass) : 64'(WGT_ONE));
        return;
      end
      cic_deposits++;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int c = 0; c < 3; c++) begin
            // Product taken stepwise, truncating after each multiply.
            t  = (64'(w[0][a]) * 64'(w[1][b])) >> FRAC_BITS;
            wp = (t * 64'(w[2][c])) >> FRAC_BITS;
            if (wp != 0) begin
              v  = use_mass ? ((wp * 64'(mass)) >> FRAC_BITS) : wp;
              // Neighbor coordinates wrap around the periodic grid.
              cx = GRID_BITS'(k[0] + a - 1);
              cy = GRID_BITS'(k[1] + b - 1);
              cz = GRID_BITS'(k[2] + c - 1);
              add_to_cell({cx, cy, cz}, v);
            end
          end
        end
      end
    endfunction

    // Called once per accepted output transfer.
    function void check_result(input logic [OUT_DATA_W-1:0] data);
      cell_read_t       e;
      logic [OUT_W-1:0] density;
      logic [CELL_W-1:0] echo;
      density = data[OUT_W-1:0];
      echo    = data[OUT_W +: CELL_W];
      if (owed.size() == 0) begin
        report($sformatf("result transfer with no read outstanding, tdata %h", data));
        return;
      end
      e = owed.pop_front();
      reads_checked++;
      if (e.density == OUT_MAX) saturated_reads++;
      if (density !== e.density || echo !== e.echo ||
          data[OUT_DATA_W-1:OUT_W+CELL_W] !== '0) begin
        report($sformatf({"read of cell %0d: expected density %h echo %0d, ",
                          "got density %h echo %0d fill %b"},
                         e.echo, e.density, e.echo, density, echo,
                         data[OUT_DATA_W-1:OUT_W+CELL_W]));
      end
    endfunction
  endclass

endpackage

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpgd_pkg::*;
  import cpgd_tb_pkg::*;

  // Cycles without any transfer before the run is declared hung. The limit leaves
  // a wide margin over the grid clear after reset and the long receiver stall.
  localparam int IDLE_LIMIT   = 150000;
  // Cycles to let a deposit still walking its corners finish before the block is
  // treated as idle: all eight corners of a cloud-in-cell deposit and the pipeline.
  localparam int DRAIN_CYCLES = 40;
  // Length of the one deliberate stretch in which the receiver refuses results.
  localparam int HOLD_CYCLES  = 3000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_scoreboard sb;

  // Cells that received deposits lately, kept as x, y, z coordinates so that
  // reads can aim at them and at their neighbors.
  logic [2:0][GRID_BITS-1:0] touched [$];
  int                        sender_burst = 0;
  int                        settings = 1;

  always #1ns clk = ~clk;

  cic_particle_grid_deposit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  // Fractions favor the points where the tent weights change shape.
  function automatic logic [FRAC_BITS-1:0] pick_frac();
    logic [FRAC_BITS-1:0] half = FRAC_BITS'(WGT_HALF);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return half;
      3: return half - 1'b1;
      4: return half + 1'b1;
      default: return FRAC_BITS'($urandom);
    endcase
  endfunction

  // A hot coordinate stays within spread cells of the center, wrapping at the
  // grid edge; a cold one lands anywhere, with the edge coordinates 0 and 31 favored.
  function automatic logic [GRID_BITS-1:0] pick_coord(input logic [GRID_BITS-1:0] center,
                                                      input int spread, input bit hot);
    if (hot) return center + GRID_BITS'($urandom_range(0, 2 * spread)) - GRID_BITS'(spread);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return GRID_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] pick_mass(input int heavy_pct);
    int r = $urandom_range(0, 99);
    if (r < heavy_pct) return '1;
    if (r < heavy_pct + 4) return '0;
    if (r < heavy_pct + 20) return MASS_W'($urandom_range(1, 65535));
    return MASS_W'($urandom);
  endfunction

  // Offers one item after a random gap and returns once the block has taken it.
  // tvalid is left high so that a following item with no gap goes straight on.
  task automatic send_item(input logic cmd, input logic [POS_W-1:0] px, py, pz,
                           input logic [MASS_W-1:0] mass,
                           input logic [CELL_W-1:0] cell_idx);
    int gap;
    if (sender_burst > 0) begin
      sender_burst--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) sender_burst = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_DATA_W'({cell_idx, mass, pz, py, px});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(cmd, px, py, pz, mass, cell_idx);
  endtask

  // Stops offering items, waits for every owed result and lets any deposit still
  // in progress run out.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on an idle block. The one-bit registers get
  // random upper bits, which the block must ignore.
  task automatic set_config(input logic mode, input logic use_mass,
                            input logic [SCALE_W-1:0] scale);
    logic [CFG_DATA_W-1:0] mode_word;
    logic [CFG_DATA_W-1:0] mass_word;
    mode_word = {31'($urandom), mode};
    mass_word = {31'($urandom), use_mass};
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ASSIGN_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    cfg_index <= REG_USE_MASS;
    cfg_data  <= mass_word;
    @(posedge clk);
    cfg_index <= REG_DENSITY_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(REG_ASSIGN_MODE, mode_word);
    sb.write_reg(REG_USE_MASS, mass_word);
    sb.write_reg(REG_DENSITY_SCALE, scale);
    settings++;
  endtask

  // One stretch of random traffic around a fresh hot spot. Reads mostly aim at
  // cells that were just deposited into, or at their neighbors, so that the
  // sums coming back are nonzero; fields the command does not use carry noise.
  task automatic run_phase(input int items, input int read_pct, input int hot_pct,
                           input int spread, input int heavy_pct);
    logic [2:0][GRID_BITS-1:0] center;
    logic [2:0][GRID_BITS-1:0] c;
    logic [2:0][POS_W-1:0]     pos;
    logic [CELL_W-1:0]         cell_idx;
    bit                        hot;
    center = (3 * GRID_BITS)'($urandom);
    repeat (items) begin
      if ($urandom_range(0, 99) < read_pct) begin
        cell_idx = CELL_W'($urandom);
        if (touched.size() > 0 && $urandom_range(0, 9) < 7) begin
          c = touched[$urandom_range(0, touched.size() - 1)];
          if ($urandom_range(0, 1) == 1) begin
            for (int a = 0; a < 3; a++) c[a] = c[a] + GRID_BITS'($urandom_range(0, 2)) - 1'b1;
          end
          cell_idx = {c[0], c[1], c[2]};
        end
        send_item(CMD_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  MASS_W'($urandom), cell_idx);
      end else begin
        hot = ($urandom_range(0, 99) < hot_pct);
        for (int a = 0; a < 3; a++) pos[a] = {pick_coord(center[a], spread, hot), pick_frac()};
        for (int a = 0; a < 3; a++) c[a] = pos[a][FRAC_BITS +: GRID_BITS];
        touched.push_back(c);
        if (touched.size() > 48) void'(touched.pop_front());
        send_item(CMD_DEPOSIT, pos[0], pos[1], pos[2], pick_mass(heavy_pct), CELL_W'($urandom));
      end
    end
  endtask

  // Results are checked at the edge where they transfer; valid is decoded from a
  // registered count and ready is a register, so the sampled values precede the edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: ready in runs of random length with random gaps, plus one long
  // refusal once traffic is well under way. During that refusal the two-entry
  // result queue fills up and the block must hold off further reads.
  initial begin : result_sink
    int  run_len;
    int  gap;
    bit  held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && sb.reads_checked >= 150) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) run_len = $urandom_range(100, 400);
      else run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      m_axis_tready <= 1'b0;
      gap = pick_gap() + 1;
      repeat (gap) @(posedge clk);
    end
  end

  // Ends the run if neither stream moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer in %0d cycles, %0d reads still owed",
             IDLE_LIMIT, sb.owed.size());
    $display("cic_particle_grid_deposit verification failed");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_DEPOSIT;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ASSIGN_MODE;
    cfg_data      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: cloud-in-cell, unit weight, unit
    // scale. The first read checks that the clear after reset left zeros.
    send_item(CMD_READ, '0, '0, '0, '0, CELL_W'(0));
    // Origin with zero fraction: half weights spill into the cells that wrap
    // around to coordinate 31 on every axis.
    send_item(CMD_DEPOSIT, 21'h00_0000, 21'h00_0000, 21'h00_0000, '1, '1);
    send_item(CMD_READ, '0, '0, '0, '0, CELL_W'(0));
    send_item(CMD_READ, '0, '0, '0, '0, CELL_W'(32767));
    send_item(CMD_READ, '0, '0, '0, '0, {5'd0, 5'd31, 5'd0});
    // Largest position: the far neighbors wrap back to coordinate 0.
    send_item(CMD_DEPOSIT, 21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF, '0, '0);
    send_item(CMD_READ, '1, '1, '1, '1, CELL_W'(32767));
    send_item(CMD_READ, '0, '0, '0, '0, CELL_W'(0));
    send_item(CMD_READ, '0, '0, '0, '0, {5'd31, 5'd0, 5'd0});
    // Fraction exactly one half: the whole unit weight lands in one cell.
    send_item(CMD_DEPOSIT, 21'h10_8000, 21'h10_8000, 21'h10_8000, '0, '0);
    send_item(CMD_READ, '0, '0, '0, '0, {5'd16, 5'd16, 5'd16});
    // Fractions one step either side of a half, where one neighbor weight is a
    // single unit and truncates away.
    send_item(CMD_DEPOSIT, 21'h0F_7FFF, 21'h10_8001, 21'h1F_0000, '0, '0);
    send_item(CMD_READ, '0, '0, '0, '0, {5'd15, 5'd16, 5'd31});
    send_item(CMD_READ, '0, '0, '0, '0, {5'd15, 5'd16, 5'd30});
    send_item(CMD_READ, '0, '0, '0, '0, {5'd14, 5'd17, 5'd31});
    send_item(CMD_READ, '0, '0, '0, '0, CELL_W'(15'h5555));
    send_item(CMD_READ, '0, '0, '0, '0, CELL_W'(15'h2AAA));

    run_phase(280, 30, 60, 1, 10);

    set_config(MODE_CIC, 1'b1, SCALE_W'($urandom));
    run_phase(380, 30, 60, 1, 15);

    // Zero scale: every read must come back as zero.
    set_config(MODE_NGP, 1'b0, '0);
    run_phase(150, 30, 50, 1, 10);

    // Pile heavy particles onto one cell until its sum times the largest scale
    // runs past the output range and the readout saturates.
    set_config(MODE_NGP, 1'b1, '1);
    run_phase(400, 15, 100, 0, 80);

    set_config(MODE_CIC, 1'b1, '1);
    run_phase(300, 35, 70, 1, 30);

    // Smallest nonzero scale: sums are divided by 65536 on readout.
    set_config(MODE_CIC, 1'b0, SCALE_W'(1));
    run_phase(250, 30, 60, 1, 10);

    set_config(MODE_NGP, 1'b0, SCALE_W'($urandom_range(65536, 1 << 20)));
    run_phase(250, 30, 40, 1, 10);

    quiesce();
    $display("covered %0d cloud-in-cell and %0d nearest-grid-point deposits over %0d settings",
             sb.cic_deposits, sb.ngp_deposits, settings);
    $display("checked %0d cell reads, %0d at the readout limit; %0d mismatches",
             sb.reads_checked, sb.saturated_reads, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("cic_particle_grid_deposit verification clean");
    end else begin
      $display("cic_particle_grid_deposit verification failed");
    end
    $finish;
  end

endmodule
